// ----- rtl/stable_priority_queue_cutoff_defines.svh -----
// Assertion macros shared by the checker of the stable priority queue.
`ifndef STABLE_PRIORITY_QUEUE_CUTOFF_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_CUTOFF_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPQC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/spqc_pkg.sv -----
// Types and constants of the stable priority queue with cutoff.
package spqc_pkg;

    localparam int QUEUE_DEPTH    = 64;
    localparam int PAYLOAD_BITS   = 32;
    localparam int PHASE_BITS     = 4;
    localparam int COUNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_TDATA_BITS  = ((PHASE_BITS + PAYLOAD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((PHASE_BITS + PAYLOAD_BITS + COUNT_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_BITS = 3;

    // Bit positions in the result tuser.
    localparam int TUSER_POP_VALID   = 0;
    localparam int TUSER_EMPTY_ERROR = 1;
    localparam int TUSER_FULL_DROP   = 2;

    localparam logic [PHASE_BITS-1:0] CUTOFF_RESET = PHASE_BITS'(4);

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } t_func;

    typedef struct packed {
        logic [PHASE_BITS-1:0]   phase;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_slot;

    typedef struct packed {
        logic load;       // take the pushed entry
        logic from_prev;  // shift toward the tail
        logic from_next;  // shift toward the head
    } t_cell_cmd;

endpackage

// ----- rtl/stable_priority_queue_cutoff.sv -----
// Stable priority queue with a sorted-insert cutoff, built as a chain of slot cells.
//
// Takes one push or pop beat per clock. Occupied cells compare their stored phase with
// the pushed phase in parallel; a phase at or below the cutoff goes in at the first
// greater slot, else at the tail, and the chain is updated in that same cycle. The
// result is in the output register the cycle after acceptance. The only thing that
// holds the input back is that output register: a new beat is taken whenever the
// register is empty or its result is taken in the same cycle. No clearing pass runs
// after reset; slots at or beyond the occupancy are never read. The cutoff register is
// written through i_cfg_we / i_cfg_wdata; the user, not the block, keeps this to idle.
module stable_priority_queue_cutoff (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [spqc_pkg::PHASE_BITS-1:0]      i_cfg_wdata,     // priority_cutoff
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [spqc_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,    // entry_phase, entry_payload
    input  logic                                 s_axis_tuser,    // func
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [spqc_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,    // head_phase, head_payload,
                                                                  // occupancy
    output logic [spqc_pkg::OUT_TUSER_BITS-1:0]  m_axis_tuser     // pop_valid, empty_error,
                                                                  // full_drop
);
    import spqc_pkg::*;

    logic [PHASE_BITS-1:0]   r_cutoff;
    logic [COUNT_BITS-1:0]   r_count;
    logic [COUNT_BITS-1:0]   n_count;
    logic                    r_out_valid;
    logic [OUT_TDATA_BITS-1:0] r_out_data;
    logic [OUT_TDATA_BITS-1:0] n_out_data;
    logic [OUT_TUSER_BITS-1:0] r_out_user;
    logic [OUT_TUSER_BITS-1:0] n_out_user;

    logic                    accept;
    logic                    is_push;
    logic                    full;
    logic                    empty;
    logic                    push_ok;
    logic                    pop_ok;
    logic                    sort;
    logic                    any_gt;
    t_slot                   new_slot;

    t_slot                   slots  [QUEUE_DEPTH];
    t_cell_cmd               cmds   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]  active;
    logic [QUEUE_DEPTH-1:0]  at_tail;
    logic [QUEUE_DEPTH-1:0]  gt;
    logic [QUEUE_DEPTH-1:0]  earlier_gt;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_push       = (t_func'(s_axis_tuser) == FUNC_PUSH);
    assign full          = (r_count == COUNT_BITS'(QUEUE_DEPTH));
    assign empty         = (r_count == '0);
    assign push_ok       = accept && is_push && !full;
    assign pop_ok        = accept && !is_push && !empty;

    assign new_slot.phase   = s_axis_tdata[PHASE_BITS-1:0];
    assign new_slot.payload = s_axis_tdata[PHASE_BITS +: PAYLOAD_BITS];
    assign sort             = (new_slot.phase <= r_cutoff);
    assign any_gt           = |gt;

    for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
        assign active[j]  = (COUNT_BITS'(j) < r_count);
        assign at_tail[j] = (COUNT_BITS'(j) == r_count);

        if (j == 0) begin : g_first
            assign earlier_gt[j] = 1'b0;
        end else begin : g_rest
            assign earlier_gt[j] = |gt[j-1:0];
        end

        // Insert at the first greater slot when the phase is at or below the cutoff, else at the tail.
        assign cmds[j].load      = push_ok && ((sort && any_gt) ? (gt[j] && !earlier_gt[j])
                                                                 : at_tail[j]);
        assign cmds[j].from_prev = push_ok && sort && earlier_gt[j];
        assign cmds[j].from_next = pop_ok;

        t_slot prev_slot;
        t_slot next_slot;
        if (j == 0) begin : g_prev_head
            assign prev_slot = new_slot;
        end else begin : g_prev_link
            assign prev_slot = slots[j-1];
        end
        if (j == QUEUE_DEPTH - 1) begin : g_next_tail
            assign next_slot = slots[j];
        end else begin : g_next_link
            assign next_slot = slots[j+1];
        end

        spqc_cell u_cell (
            .i_clk    (i_clk),
            .i_active (active[j]),
            .i_phase  (new_slot.phase),
            .i_cmd    (cmds[j]),
            .i_new    (new_slot),
            .i_prev   (prev_slot),
            .i_next   (next_slot),
            .o_slot   (slots[j]),
            .o_gt     (gt[j])
        );
    end

    always_comb begin
        n_count = r_count;
        if (push_ok) begin
            n_count = r_count + COUNT_BITS'(1);
        end else if (pop_ok) begin
            n_count = r_count - COUNT_BITS'(1);
        end
    end

    always_comb begin
        n_out_data = '0;
        n_out_user = '0;
        n_out_data[PHASE_BITS + PAYLOAD_BITS +: COUNT_BITS] = n_count;
        if (pop_ok) begin
            n_out_data[PHASE_BITS-1:0]            = slots[0].phase;
            n_out_data[PHASE_BITS +: PAYLOAD_BITS] = slots[0].payload;
            n_out_user[TUSER_POP_VALID]            = 1'b1;
        end
        n_out_user[TUSER_EMPTY_ERROR] = !is_push && empty;
        n_out_user[TUSER_FULL_DROP]   = is_push && full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff    <= CUTOFF_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cutoff <= i_cfg_wdata;
            end
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result register only when a beat is accepted.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ----- rtl/spqc_cell.sv -----
// One slot of the queue chain: holds an entry and compares it to a pushed phase.
module spqc_cell (
    input  logic                         i_clk,
    input  logic                         i_active,
    input  logic [spqc_pkg::PHASE_BITS-1:0] i_phase,
    input  spqc_pkg::t_cell_cmd          i_cmd,
    input  spqc_pkg::t_slot              i_new,
    input  spqc_pkg::t_slot              i_prev,
    input  spqc_pkg::t_slot              i_next,
    output spqc_pkg::t_slot              o_slot,
    output logic                         o_gt
);
    import spqc_pkg::*;

    t_slot r_slot;
    t_slot n_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_cmd.load) begin
            n_slot = i_new;
        end else if (i_cmd.from_prev) begin
            n_slot = i_prev;
        end else if (i_cmd.from_next) begin
            n_slot = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;
    assign o_gt   = i_active && (r_slot.phase > i_phase);

endmodule

// ----- rtl/spqc_checker.sv -----
// Port-level checker for the stable priority queue, bound to the top level.
`include "stable_priority_queue_cutoff_defines.svh"

module spqc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [spqc_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    input logic [spqc_pkg::OUT_TUSER_BITS-1:0] m_axis_tuser
);
    import spqc_pkg::*;

    logic [COUNT_BITS-1:0] occ;
    logic                  pop_valid;
    logic                  empty_error;

    assign occ         = m_axis_tdata[PHASE_BITS + PAYLOAD_BITS +: COUNT_BITS];
    assign pop_valid   = m_axis_tuser[TUSER_POP_VALID];
    assign empty_error = m_axis_tuser[TUSER_EMPTY_ERROR];

    `SPQC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")
    `SPQC_ASSERT_IMP(a_flags_exclusive, i_clk, i_rst_n, m_axis_tvalid, $onehot0(m_axis_tuser), "more than one result flag set")
    `SPQC_ASSERT_IMP(a_occ_bound, i_clk, i_rst_n, m_axis_tvalid, occ <= COUNT_BITS'(QUEUE_DEPTH), "occupancy above queue depth")
    `SPQC_ASSERT_IMP(a_head_zero, i_clk, i_rst_n, m_axis_tvalid && !pop_valid, m_axis_tdata[PHASE_BITS + PAYLOAD_BITS - 1:0] == '0, "head fields not zero without a popped entry")
    `SPQC_ASSERT_IMP(a_empty_occ, i_clk, i_rst_n, m_axis_tvalid && empty_error, occ == '0, "empty error with nonzero occupancy")

endmodule

bind stable_priority_queue_cutoff spqc_checker u_spqc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- verif/tb.sv -----
// Self-checking testbench for the stable priority queue with sorted-insert cutoff.
module tb;
    import spqc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        t_func                   func;
        logic [PHASE_BITS-1:0]   phase;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_request;

    typedef struct packed {
        logic                    pop_valid;
        logic [PHASE_BITS-1:0]   head_phase;
        logic [PAYLOAD_BITS-1:0] head_payload;
        logic                    empty_error;
        logic                    full_drop;
        logic [COUNT_BITS-1:0]   occupancy;
    } t_outcome;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [PHASE_BITS-1:0]      i_cfg_wdata = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_TDATA_BITS-1:0]   s_axis_tdata = '0;   // entry_phase, entry_payload
    logic                       s_axis_tuser = 1'b0; // func
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0]  m_axis_tdata;        // head_phase, head_payload, occupancy
    logic [OUT_TUSER_BITS-1:0]  m_axis_tuser;        // pop_valid, empty_error, full_drop

    stable_priority_queue_cutoff u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // shadow copy of the queue contents and the cutoff register
    t_slot                 shadow_slots[$];
    logic [PHASE_BITS-1:0] shadow_cutoff = CUTOFF_RESET;

    t_request pending_requests[$];
    t_outcome expected_outcomes[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  items_issued = 0;
    int  items_taken = 0;
    int  errors = 0;
    int  gen_level = 0;
    int  n_push = 0, n_drop = 0, n_pop = 0, n_empty = 0, n_sorted = 0;
    bit  in_beat_taken = 1'b0;

    function automatic t_outcome serve_request(t_request r);
        t_outcome o;
        t_slot    s;
        int       pos;
        o = '0;
        if (r.func == FUNC_PUSH) begin
            n_push++;
            if (shadow_slots.size() >= QUEUE_DEPTH) begin
                o.full_drop = 1'b1;
                n_drop++;
            end else begin
                s.phase = r.phase;
                s.payload = r.payload;
                pos = shadow_slots.size();
                // scan every stored entry, appended ones too, up to the first greater phase
                if (r.phase <= shadow_cutoff) begin
                    pos = 0;
                    while (pos < shadow_slots.size() && shadow_slots[pos].phase <= r.phase)
                        pos++;
                    if (pos < shadow_slots.size())
                        n_sorted++;
                end
                shadow_slots.insert(pos, s);
            end
        end else begin
            n_pop++;
            if (shadow_slots.size() == 0) begin
                o.empty_error = 1'b1;
                n_empty++;
            end else begin
                o.pop_valid = 1'b1;
                o.head_phase = shadow_slots[0].phase;
                o.head_payload = shadow_slots[0].payload;
                void'(shadow_slots.pop_front());
            end
        end
        o.occupancy = COUNT_BITS'(shadow_slots.size());
        return o;
    endfunction

    task automatic check_field(string fname, logic [63:0] want, logic [63:0] got_v);
        if (got_v !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, fname, want, got_v);
        end
    endtask

    // input driver: hold a beat until taken, then idle or present the next one
    always @(negedge i_clk) begin : drive_input
        t_request next_req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_beat_taken) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_req = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= next_req.func;
                s_axis_tdata  <= IN_TDATA_BITS'({next_req.payload, next_req.phase});
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor: check results first, then predict the beat taken at this edge
    always @(posedge i_clk) begin : watch_ports
        t_outcome got, want;
        t_request req;
        in_beat_taken = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.head_phase   = m_axis_tdata[PHASE_BITS-1:0];
                got.head_payload = m_axis_tdata[PHASE_BITS +: PAYLOAD_BITS];
                got.occupancy    = m_axis_tdata[PHASE_BITS+PAYLOAD_BITS +: COUNT_BITS];
                got.pop_valid    = m_axis_tuser[TUSER_POP_VALID];
                got.empty_error  = m_axis_tuser[TUSER_EMPTY_ERROR];
                got.full_drop    = m_axis_tuser[TUSER_FULL_DROP];
                if (expected_outcomes.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got 0x%0h",
                             $time, got);
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("pop_valid", 64'(want.pop_valid), 64'(got.pop_valid));
                    check_field("head_phase", 64'(want.head_phase), 64'(got.head_phase));
                    check_field("head_payload", 64'(want.head_payload),
                                64'(got.head_payload));
                    check_field("empty_error", 64'(want.empty_error),
                                64'(got.empty_error));
                    check_field("full_drop", 64'(want.full_drop), 64'(got.full_drop));
                    check_field("occupancy", 64'(want.occupancy), 64'(got.occupancy));
                end
            end
            in_beat_taken = s_axis_tvalid && s_axis_tready;
            if (in_beat_taken) begin
                req.func    = t_func'(s_axis_tuser);
                req.phase   = s_axis_tdata[PHASE_BITS-1:0];
                req.payload = s_axis_tdata[PHASE_BITS +: PAYLOAD_BITS];
                items_taken++;
                expected_outcomes.push_back(serve_request(req));
            end
        end
    end

    task automatic queue_request(t_func f, logic [PHASE_BITS-1:0] ph,
                                 logic [PAYLOAD_BITS-1:0] pl);
        t_request r;
        r.func = f;
        r.phase = ph;
        r.payload = pl;
        pending_requests.push_back(r);
        items_issued++;
        if (f == FUNC_PUSH) begin
            if (gen_level < QUEUE_DEPTH)
                gen_level++;
        end else if (gen_level > 0) begin
            gen_level--;
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (items_taken != items_issued || expected_outcomes.size() != 0);
    endtask

    task automatic write_cutoff(logic [PHASE_BITS-1:0] v);
        wait_drained();
        repeat (3) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        shadow_cutoff = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [PAYLOAD_BITS-1:0] pick_payload();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return PAYLOAD_BITS'($urandom);
        endcase
    endfunction

    task automatic add_random_chunk();
        int lo, hi, n, push_pct;
        // full phase range, or a narrow band that piles up equal phases
        if ($urandom_range(0, 1)) begin
            lo = 0;
            hi = 15;
        end else begin
            lo = $urandom_range(0, 13);
            hi = lo + 2;
        end
        case ($urandom_range(0, 9))
            0: begin
                // fill past full
                n = QUEUE_DEPTH - gen_level + $urandom_range(1, 3);
                repeat (n)
                    queue_request(FUNC_PUSH, PHASE_BITS'($urandom_range(lo, hi)),
                                  pick_payload());
            end
            1: begin
                // drain past empty
                n = gen_level + $urandom_range(1, 2);
                repeat (n) queue_request(FUNC_POP, PHASE_BITS'($urandom), pick_payload());
            end
            2: begin
                repeat (8)
                    queue_request(t_func'($urandom_range(0, 1)), PHASE_BITS'($urandom),
                                  pick_payload());
            end
            default: begin
                repeat (20) begin
                    push_pct = (gen_level < 8) ? 70 : (gen_level > 56) ? 30 : 50;
                    if ($urandom_range(0, 99) < push_pct)
                        queue_request(FUNC_PUSH, PHASE_BITS'($urandom_range(lo, hi)),
                                      pick_payload());
                    else
                        queue_request(FUNC_POP, PHASE_BITS'($urandom), pick_payload());
                end
            end
        endcase
    endtask

    initial begin
        int seg_start;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // cutoff at its reset value of 4
        queue_request(FUNC_POP,  4'd0,  32'h0);           // pop on empty
        queue_request(FUNC_PUSH, 4'd15, 32'hFFFF_FFFF);   // above cutoff, append
        queue_request(FUNC_PUSH, 4'd0,  32'h0000_0000);   // sorted, lands ahead of appended 15
        queue_request(FUNC_PUSH, 4'd4,  32'hA5A5_A5A5);   // phase equal to cutoff
        queue_request(FUNC_PUSH, 4'd4,  32'h5A5A_5A5A);   // equal phase keeps arrival order
        queue_request(FUNC_PUSH, 4'd5,  32'h1234_5678);   // above cutoff, behind the 15
        queue_request(FUNC_PUSH, 4'd2,  32'h0F0F_0F0F);
        repeat (7) queue_request(FUNC_POP, 4'd0, 32'h0); // empty it and pop once more

        for (int seg = 0; seg < 9; seg++) begin
            write_cutoff((seg % 3 == 0) ? 4'd0 : (seg % 3 == 1) ? 4'd15 :
                         PHASE_BITS'($urandom_range(0, 15)));
            if (seg < 3) begin
                send_idle_pct = 23;
                recv_idle_pct = 52;
            end else if (seg < 6) begin
                send_idle_pct = 52;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            seg_start = items_issued;
            while (items_issued - seg_start < 176) begin
                add_random_chunk();
                // hold the sender now and then until the queue of results is empty
                if ($urandom_range(0, 5) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        $display("tb: %0d beats, %0d pushes (%0d sorted ahead, %0d dropped on full)",
                 items_taken, n_push, n_sorted, n_drop);
        $display("tb: %0d pops (%0d on empty), cutoffs 0, 15 and random, three stall mixes",
                 n_pop, n_empty);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin
        #(4 * LIMIT_CYCLES);
        $display("tb: done, errors");
        $finish;
    end

endmodule
